@@ hw/rtl/qsip_pkg.sv @@
// ----------------------------------------------------------------------------
// Quicksort sorter package
// Shared widths, sizes and the range stack entry type for the in-place sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package qsip_pkg;

    // Element width and store sizing.
    localparam int DATA_W      = 32;
    localparam int MAX_ITEMS   = 64;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int STACK_DEPTH = 64;

    // One entry of the range stack: low index and high index of a subrange.
    typedef struct packed {
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
    } t_range;

endpackage

`default_nettype wire

@@ hw/rtl/qsip_if.sv @@
// ----------------------------------------------------------------------------
// Quicksort sorter channels
// Valid/ready channels for loading elements and for emitting sorted elements.
// ----------------------------------------------------------------------------
`default_nettype none

// Input channel: one element per transaction.
interface qsip_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [qsip_pkg::DATA_W-1:0] value;
    logic                              is_last;

    modport source (output valid, output value, output is_last, input ready);
    modport sink   (input valid, input value, input is_last, output ready);
endinterface

// Output channel: one sorted element per transaction.
interface qsip_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [qsip_pkg::DATA_W-1:0] sorted_value;
    logic                              end_of_set;
    logic                              overflowed;

    modport source (output valid, output sorted_value, output end_of_set,
                    output overflowed, input ready);
    modport sink   (input valid, input sorted_value, input end_of_set,
                    input overflowed, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/quicksort_in_place_sorter.sv @@
// ----------------------------------------------------------------------------
// Quicksort in-place sorter
// Loads signed elements, sorts them ascending with a first-element-pivot
// quicksort over an explicit range stack, then streams them out in order.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                                 Handshake
//   i_in      in         value[31:0], is_last                    valid/ready
//   o_out     out        sorted_value[31:0], end_of_set, overflowed  valid/ready
//
// Loading accepts one element per cycle while i_in.ready is high (idle state).
// Sorting runs on one comparator and one single-write element memory with a
// registered read port: each scanned element is read and then compared, each
// swap writes both elements in turn, and a set in order or all equal is the
// worst case, since every partition then leaves one subrange of all but one.
// Emitting reads each element and then offers it until o_out.ready takes it.
// Reset clears the control state only; the memories need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module quicksort_in_place_sorter (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    qsip_in_if.sink     i_in,
    qsip_out_if.source  o_out
);

    localparam int IW = qsip_pkg::IDX_W;
    localparam int CW = qsip_pkg::CNT_W;
    localparam int DW = qsip_pkg::DATA_W;

    // Sequencer state codes.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_INIT = 4'd1;
    localparam logic [3:0] S_POP  = 4'd2;
    localparam logic [3:0] S_POPW = 4'd3;
    localparam logic [3:0] S_PIV  = 4'd4;
    localparam logic [3:0] S_L    = 4'd5;
    localparam logic [3:0] S_LC   = 4'd6;
    localparam logic [3:0] S_R    = 4'd7;
    localparam logic [3:0] S_RC   = 4'd8;
    localparam logic [3:0] S_SWP  = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;
    localparam logic [3:0] S_PUSH = 4'd11;
    localparam logic [3:0] S_ORD  = 4'd12;
    localparam logic [3:0] S_OW   = 4'd13;

    // Memories.
    logic signed [DW-1:0] r_store [qsip_pkg::MAX_ITEMS];
    qsip_pkg::t_range     r_stack [qsip_pkg::STACK_DEPTH];

    // Control registers.
    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic [CW-1:0] r_sp, n_sp;
    logic [CW-1:0] r_k, n_k;

    // Datapath registers.
    logic [IW-1:0]        r_lo, n_lo;
    logic [IW-1:0]        r_hi, n_hi;
    logic [CW-1:0]        r_i, n_i;
    logic [CW-1:0]        r_j, n_j;
    logic signed [DW-1:0] r_pivot, n_pivot;
    logic signed [DW-1:0] r_vi, n_vi;
    logic signed [DW-1:0] r_rd_data;
    qsip_pkg::t_range     r_stk_data;

    // Memory port controls.
    logic                 st_re;
    logic [IW-1:0]        st_ra;
    logic                 st_we;
    logic [IW-1:0]        st_wa;
    logic signed [DW-1:0] st_wd;
    logic                 sk_re;
    logic                 sk_we;
    qsip_pkg::t_range     sk_wd;

    // Partition result: the two subranges around the pivot position.
    logic [IW-1:0]    p_idx;
    logic             left_ok, right_ok, larger_left;
    qsip_pkg::t_range left_rng, right_rng, first_rng, second_rng;
    logic             first_ok, second_ok;
    logic             in_fire, out_fire, rd_le, stack_room;

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = (r_state == S_OW);
    assign o_out.sorted_value = r_rd_data;
    assign o_out.end_of_set   = ((r_k + CW'(1)) == r_count);
    assign o_out.overflowed   = r_ovf;

    assign in_fire    = i_in.valid && i_in.ready;
    assign out_fire   = o_out.valid && o_out.ready;
    assign rd_le      = (r_rd_data <= r_pivot);
    assign stack_room = (r_sp < CW'(qsip_pkg::STACK_DEPTH));

    // Subranges after a partition; empty and single-element ones are skipped.
    assign p_idx       = r_j[IW-1:0];
    assign left_ok     = ({1'b0, p_idx} > ({1'b0, r_lo} + CW'(1)));
    assign right_ok    = (({1'b0, p_idx} + CW'(1)) < {1'b0, r_hi});
    assign larger_left = ((p_idx - r_lo) > (r_hi - p_idx));
    assign left_rng    = '{lo: r_lo, hi: p_idx - IW'(1)};
    assign right_rng   = '{lo: p_idx + IW'(1), hi: r_hi};
    assign first_rng   = larger_left ? left_rng : right_rng;
    assign first_ok    = larger_left ? left_ok : right_ok;
    assign second_rng  = larger_left ? right_rng : left_rng;
    assign second_ok   = larger_left ? right_ok : left_ok;

    // Sequencer next-state and port control.
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ovf   = r_ovf;
        n_sp    = r_sp;
        n_k     = r_k;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_i     = r_i;
        n_j     = r_j;
        n_pivot = r_pivot;
        n_vi    = r_vi;
        st_re   = 1'b0;
        st_ra   = r_i[IW-1:0];
        st_we   = 1'b0;
        st_wa   = r_count[IW-1:0];
        st_wd   = i_in.value;
        sk_re   = 1'b0;
        sk_we   = 1'b0;
        sk_wd   = first_rng;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (r_count < CW'(qsip_pkg::MAX_ITEMS)) begin
                        st_we   = 1'b1;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in.is_last) begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                // Whole set is the first range when it holds two or more.
                n_sp = '0;
                if (r_count > CW'(1)) begin
                    sk_we = 1'b1;
                    sk_wd = '{lo: '0, hi: IW'(r_count - CW'(1))};
                    n_sp  = CW'(1);
                end
                n_state = S_POP;
            end
            S_POP: begin
                if (r_sp == '0) begin
                    n_k     = '0;
                    n_state = S_ORD;
                end else begin
                    sk_re   = 1'b1;
                    n_sp    = r_sp - CW'(1);
                    n_state = S_POPW;
                end
            end
            S_POPW: begin
                n_lo = r_stk_data.lo;
                n_hi = r_stk_data.hi;
                if (r_stk_data.lo >= r_stk_data.hi) begin
                    n_state = S_POP;
                end else begin
                    st_re   = 1'b1;
                    st_ra   = r_stk_data.lo;
                    n_i     = {1'b0, r_stk_data.lo} + CW'(1);
                    n_j     = {1'b0, r_stk_data.hi} + CW'(1);
                    n_state = S_PIV;
                end
            end
            S_PIV: begin
                n_pivot = r_rd_data;
                n_state = S_L;
            end
            S_L: begin
                // Left scan checks the range end before reading.
                if (r_i > {1'b0, r_hi}) begin
                    n_j     = r_j - CW'(1);
                    n_state = S_R;
                end else begin
                    st_re   = 1'b1;
                    st_ra   = r_i[IW-1:0];
                    n_state = S_LC;
                end
            end
            S_LC: begin
                if (rd_le) begin
                    n_i     = r_i + CW'(1);
                    n_state = S_L;
                end else begin
                    n_vi    = r_rd_data;
                    n_j     = r_j - CW'(1);
                    n_state = S_R;
                end
            end
            S_R: begin
                st_re   = 1'b1;
                st_ra   = r_j[IW-1:0];
                n_state = S_RC;
            end
            S_RC: begin
                if (!rd_le) begin
                    n_j     = r_j - CW'(1);
                    n_state = S_R;
                end else if (r_i < r_j) begin
                    st_we   = 1'b1;
                    st_wa   = r_i[IW-1:0];
                    st_wd   = r_rd_data;
                    n_state = S_SWP;
                end else begin
                    st_we   = 1'b1;
                    st_wa   = r_lo;
                    st_wd   = r_rd_data;
                    n_state = S_FIN;
                end
            end
            S_SWP: begin
                st_we   = 1'b1;
                st_wa   = r_j[IW-1:0];
                st_wd   = r_vi;
                n_i     = r_i + CW'(1);
                n_state = S_L;
            end
            S_FIN: begin
                // Pivot goes to its final place; larger subrange is pushed first.
                st_we = 1'b1;
                st_wa = r_j[IW-1:0];
                st_wd = r_pivot;
                if (first_ok && stack_room) begin
                    sk_we = 1'b1;
                    sk_wd = first_rng;
                    n_sp  = r_sp + CW'(1);
                end
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (second_ok && stack_room) begin
                    sk_we = 1'b1;
                    sk_wd = second_rng;
                    n_sp  = r_sp + CW'(1);
                end
                n_state = S_POP;
            end
            S_ORD: begin
                st_re   = 1'b1;
                st_ra   = r_k[IW-1:0];
                n_state = S_OW;
            end
            S_OW: begin
                if (out_fire) begin
                    if ((r_k + CW'(1)) == r_count) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_sp    = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + CW'(1);
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_sp    <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_sp    <= n_sp;
            r_k     <= n_k;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_i     <= n_i;
        r_j     <= n_j;
        r_pivot <= n_pivot;
        r_vi    <= n_vi;
    end

    // Element memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store[st_wa] <= st_wd;
        end
        if (st_re) begin
            r_rd_data <= r_store[st_ra];
        end
    end

    // Range stack memory: push at the pointer, pop reads one below it.
    always_ff @(posedge i_clk) begin
        if (sk_we) begin
            r_stack[r_sp[IW-1:0]] <= sk_wd;
        end
        if (sk_re) begin
            r_stk_data <= r_stack[IW'(r_sp - CW'(1))];
        end
    end

    // The element count never exceeds the store size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(qsip_pkg::MAX_ITEMS))
        else $error("element count beyond store size");

    // The stack pointer never exceeds the stack depth.
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= CW'(qsip_pkg::STACK_DEPTH))
        else $error("range stack pointer beyond depth");

    // The left scan never runs more than one past the range end.
    a_left_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_L) |-> (r_i <= ({1'b0, r_hi} + CW'(1))))
        else $error("left scan ran past the range");

    // The right scan always stops at or above the range start.
    a_right_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RC) |-> (r_j >= {1'b0, r_lo}))
        else $error("right scan ran below the range");

    // A result is only offered for a nonempty set.
    a_out_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_count != '0))
        else $error("result offered for an empty set");

endmodule

`default_nettype wire
